### hdl/clfp_pkg.sv
// Shared types, register map, error codes and character constants of the frame parser.
package clfp_pkg;

    localparam int AddrW = 4;

    typedef struct packed {
        logic [31:0] max_body_len;
        logic [7:0]  max_header_count;
        logic [15:0] max_line_len;
    } clfp_cfg_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] body_byte;
        logic       last;
        logic [2:0] error_code;
    } clfp_result_t;

    localparam logic [31:0] MAX_BODY_LEN_RST     = 32'd16777216;
    localparam logic [7:0]  MAX_HEADER_COUNT_RST = 8'd32;
    localparam logic [15:0] MAX_LINE_LEN_RST     = 16'd8192;

    localparam logic [1:0] REG_MAX_BODY_LEN     = 2'd0;
    localparam logic [1:0] REG_MAX_HEADER_COUNT = 2'd1;
    localparam logic [1:0] REG_MAX_LINE_LEN     = 2'd2;

    localparam logic KIND_BODY  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [2:0] ERR_MISSING_LF    = 3'd0;
    localparam logic [2:0] ERR_LINE_TOO_LONG = 3'd1;
    localparam logic [2:0] ERR_TOO_MANY_HDRS = 3'd2;
    localparam logic [2:0] ERR_BAD_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_NO_LENGTH     = 3'd4;
    localparam logic [2:0] ERR_EMPTY_BODY    = 3'd5;
    localparam logic [2:0] ERR_EARLY_END     = 3'd6;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] NAME_LEN = 5'd14;

    // Lower-case spelling of the length header name.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

### hdl/clfp_cfg.sv
// Configuration register file of the frame parser behind an APB-style port.
module clfp_cfg
    import clfp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output clfp_cfg_t        cfg
);

    clfp_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_body_len     <= MAX_BODY_LEN_RST;
            cfg_reg.max_header_count <= MAX_HEADER_COUNT_RST;
            cfg_reg.max_line_len     <= MAX_LINE_LEN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_BODY_LEN:     cfg_reg.max_body_len     <= pwdata;
                REG_MAX_HEADER_COUNT: cfg_reg.max_header_count <= pwdata[7:0];
                REG_MAX_LINE_LEN:     cfg_reg.max_line_len     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_BODY_LEN:     prdata = cfg_reg.max_body_len;
            REG_MAX_HEADER_COUNT: prdata = {24'd0, cfg_reg.max_header_count};
            REG_MAX_LINE_LEN:     prdata = {16'd0, cfg_reg.max_line_len};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

### hdl/clfp_deframer.sv
// Header and body tracking state with the per-beat next-state and result logic.
module clfp_deframer
    import clfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  clfp_cfg_t    cfg,
    input  logic         in_accept,
    input  logic [7:0]   in_data,
    input  logic         in_eos,
    output clfp_result_t result
);

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DEAD} phase_t;
    typedef enum logic [1:0] {VS_BLANKS, VS_DIGITS, VS_BAD} vstat_t;

    phase_t      phase_reg, phase_next;
    logic        cr_pending_reg, cr_pending_next;
    logic [16:0] line_length_reg, line_length_next;
    logic [8:0]  header_count_reg, header_count_next;
    logic [4:0]  name_pos_reg, name_pos_next;
    logic        name_match_reg, name_match_next;
    logic        colon_seen_reg, colon_seen_next;
    vstat_t      vstat_reg, vstat_next;
    logic [31:0] acc_reg, acc_next;
    logic        len_known_reg, len_known_next;
    logic [31:0] wanted_reg, wanted_next;
    logic [31:0] body_count_reg, body_count_next;

    logic [16:0] line_inc;
    logic [8:0]  hdr_inc;
    logic [31:0] body_inc;
    logic [35:0] acc_times_ten;
    logic        is_digit;
    logic        is_blank;
    logic        clear_line;
    logic        clear_frame;

    assign line_inc      = line_length_reg + 17'd1;
    assign hdr_inc       = header_count_reg + 9'd1;
    assign body_inc      = body_count_reg + 32'd1;
    assign is_digit      = (in_data >= CHAR_ZERO) && (in_data <= CHAR_NINE);
    assign is_blank      = (in_data == CHAR_SPACE) || (in_data == CHAR_TAB);
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {32'd0, in_data[3:0]};

    always_comb begin
        phase_next        = phase_reg;
        cr_pending_next   = cr_pending_reg;
        line_length_next  = line_length_reg;
        header_count_next = header_count_reg;
        name_pos_next     = name_pos_reg;
        name_match_next   = name_match_reg;
        colon_seen_next   = colon_seen_reg;
        vstat_next        = vstat_reg;
        acc_next          = acc_reg;
        len_known_next    = len_known_reg;
        wanted_next       = wanted_reg;
        body_count_next   = body_count_reg;
        clear_line        = 1'b0;
        clear_frame       = 1'b0;
        result            = '0;

        case (phase_reg)
            PH_HEADER, PH_BODY: begin
                if (in_eos) begin
                    if (phase_reg == PH_BODY || cr_pending_reg || line_length_reg != 17'd0
                        || len_known_reg) begin
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_EARLY_END;
                    end
                end else if (phase_reg == PH_BODY) begin
                    body_count_next  = body_inc;
                    result.valid     = 1'b1;
                    result.kind      = KIND_BODY;
                    result.body_byte = in_data;
                    if (body_inc == wanted_reg) begin
                        result.last = 1'b1;
                        clear_frame = 1'b1;
                    end
                end else if (cr_pending_reg) begin
                    cr_pending_next = 1'b0;
                    if (in_data != CHAR_LF) begin
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_MISSING_LF;
                    end else if (line_length_reg == 17'd0) begin
                        if (!len_known_reg) begin
                            result.valid      = 1'b1;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_NO_LENGTH;
                        end else if (wanted_reg == 32'd0) begin
                            result.valid      = 1'b1;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_EMPTY_BODY;
                        end else begin
                            phase_next      = PH_BODY;
                            body_count_next = 32'd0;
                        end
                    end else begin
                        header_count_next = hdr_inc;
                        if (hdr_inc > {1'b0, cfg.max_header_count}) begin
                            result.valid      = 1'b1;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_TOO_MANY_HDRS;
                        end else if (colon_seen_reg && name_match_reg
                                     && vstat_reg != VS_DIGITS) begin
                            result.valid      = 1'b1;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_BAD_LENGTH;
                        end else begin
                            if (colon_seen_reg && name_match_reg) begin
                                wanted_next    = acc_reg;
                                len_known_next = 1'b1;
                            end
                            clear_line = 1'b1;
                        end
                    end
                end else if (in_data == CHAR_CR) begin
                    cr_pending_next = 1'b1;
                end else begin
                    line_length_next = line_inc;
                    if (line_inc > {1'b0, cfg.max_line_len}) begin
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_LINE_TOO_LONG;
                    end else if (!colon_seen_reg) begin
                        if (in_data == CHAR_COLON) begin
                            colon_seen_next = 1'b1;
                            name_match_next = name_match_reg && (name_pos_reg == NAME_LEN);
                        end else if (name_pos_reg < NAME_LEN) begin
                            if (to_lower(in_data) != name_char(name_pos_reg[3:0])) begin
                                name_match_next = 1'b0;
                            end
                            name_pos_next = name_pos_reg + 5'd1;
                        end else begin
                            name_match_next = 1'b0;
                        end
                    end else if (name_match_reg && vstat_reg != VS_BAD
                                 && !(vstat_reg == VS_BLANKS && is_blank)) begin
                        if (!is_digit) begin
                            vstat_next = VS_BAD;
                        end else if (acc_times_ten > {4'd0, cfg.max_body_len}) begin
                            vstat_next = VS_BAD;
                        end else begin
                            acc_next   = acc_times_ten[31:0];
                            vstat_next = VS_DIGITS;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (result.valid && result.kind == KIND_ERROR) begin
            phase_next = PH_DEAD;
        end

        if (clear_line || clear_frame) begin
            line_length_next = 17'd0;
            name_pos_next    = 5'd0;
            name_match_next  = 1'b1;
            colon_seen_next  = 1'b0;
            vstat_next       = VS_BLANKS;
            acc_next         = 32'd0;
        end
        if (clear_frame) begin
            phase_next        = PH_HEADER;
            cr_pending_next   = 1'b0;
            header_count_next = 9'd0;
            len_known_next    = 1'b0;
            wanted_next       = 32'd0;
            body_count_next   = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            cr_pending_reg   <= 1'b0;
            line_length_reg  <= 17'd0;
            header_count_reg <= 9'd0;
            name_pos_reg     <= 5'd0;
            name_match_reg   <= 1'b1;
            colon_seen_reg   <= 1'b0;
            vstat_reg        <= VS_BLANKS;
            acc_reg          <= 32'd0;
            len_known_reg    <= 1'b0;
            wanted_reg       <= 32'd0;
            body_count_reg   <= 32'd0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            cr_pending_reg   <= cr_pending_next;
            line_length_reg  <= line_length_next;
            header_count_reg <= header_count_next;
            name_pos_reg     <= name_pos_next;
            name_match_reg   <= name_match_next;
            colon_seen_reg   <= colon_seen_next;
            vstat_reg        <= vstat_next;
            acc_reg          <= acc_next;
            len_known_reg    <= len_known_next;
            wanted_reg       <= wanted_next;
            body_count_reg   <= body_count_next;
        end
    end

endmodule

### hdl/clfp_out_reg.sv
// Output register that holds one result beat and frees the input side while it drains.
module clfp_out_reg
    import clfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  clfp_result_t result,
    output logic         load_ok,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,
    output logic         m_tuser,
    output logic         m_tlast
);

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [2:0] code_reg;

    assign load_ok  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, code_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_accept) begin
            valid_reg <= result.valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg <= result.kind;
            byte_reg <= result.body_byte;
            last_reg <= result.last;
            code_reg <= result.error_code;
        end
    end

endmodule

### hdl/content_length_frame_parser.sv
// Top level of the Content-Length frame parser: configuration, deframer and output register.
//
//   Channel  Ports                 Direction  Carries
//   input    s_tvalid/s_tready...  in         tdata[7:0] data, tuser end_of_stream
//   result   m_tvalid/m_tready...  out        tdata[7:0] body_byte, tdata[10:8] error_code,
//                                             tuser kind, tlast last
//   config   psel/penable/...      in         max_body_len 0x0, max_header_count 0x4,
//                                             max_line_len 0x8
//
// One beat per cycle unless stalled; its result is in the output register the next cycle.
// The deframer state and the output register both update at the accepting edge.
// A waiting result stalls input only when the output register is full and not taken.
// Reset is synchronous and returns the parser to the header phase with default limits.
module content_length_frame_parser
    import clfp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data
    input  logic             s_tuser,   // [0] end_of_stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] body_byte, [10:8] error_code
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    clfp_cfg_t    cfg;
    clfp_result_t result;
    logic         load_ok;
    logic         in_accept;

    assign s_tready  = load_ok;
    assign in_accept = s_tvalid && s_tready;

    clfp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clfp_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_data   (s_tdata),
        .in_eos    (s_tuser),
        .result    (result)
    );

    clfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .result    (result),
        .load_ok   (load_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### hdl/clfp_checker.sv
// Port-level checks of the frame parser and the bind that attaches them.
module clfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // An empty output register never stalls the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // Error beats carry no body byte and no last flag.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[7:0] == 8'd0)
        else $error("error beat carries body fields");

    // After an error beat is taken the parser gives nothing more.
    a_dead_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid)
        else $error("result beat after an error");

    // A stalled result beat holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind content_length_frame_parser clfp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
